// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file owbm_checker.sv
// no dependencies; each macro expects i_clk and i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define A_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define A_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/owbm_pkg.sv -----
// types, constants and the crc helper for the 1-wire bus master
// no dependencies
package owbm_pkg;

    localparam int TICK_CNT_W_DEF = 10;
    localparam int BITS_PER_BYTE  = 8;
    localparam int BIT_IDX_W      = $clog2(BITS_PER_BYTE);
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 10;
    localparam int IN_TDATA_W     = 16;
    localparam int IN_TUSER_W     = 2;
    localparam int OUT_TDATA_W    = 24;

    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_WAIT  = 4'd2,
        PH_RST_RECOV = 4'd3,
        PH_WR_SLOT   = 4'd4,
        PH_RD_SLOT   = 4'd5,
        PH_GAP       = 4'd6
    } t_phase;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_RESET = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOV   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_LOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_GAP       = 3'd7;

    typedef struct packed {
        logic [9:0] reset_low;
        logic [9:0] presence_wait;
        logic [9:0] reset_recov;
        logic [5:0] write_one_low;
        logic [7:0] slot;
        logic [5:0] read_low;
        logic [5:0] read_sample;
        logic [5:0] bit_gap;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        reset_low:     10'd500,
        presence_wait: 10'd100,
        reset_recov:   10'd200,
        write_one_low: 6'd5,
        slot:          8'd60,
        read_low:      6'd2,
        read_sample:   6'd12,
        bit_gap:       6'd2
    };

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       no_device;
        logic [7:0] rx_byte;
        logic [7:0] crc_value;
        logic       rejected;
    } t_result;

    // reflected dallas crc-8, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       mix;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            mix = c[0] ^ data[i];
            c   = {1'b0, c[7:1]};
            if (mix) begin
                c = c ^ CRC_POLY_REFL;
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/owbm_cfg_regs.sv -----
// configuration register file for the 1-wire bus master
// depends on owbm_pkg
module owbm_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [owbm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output owbm_pkg::t_cfg                  o_cfg
);
    import owbm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RESET_LOW:     r_cfg.reset_low     <= i_cfg_data;
                REG_PRESENCE_WAIT: r_cfg.presence_wait <= i_cfg_data;
                REG_RESET_RECOV:   r_cfg.reset_recov   <= i_cfg_data;
                REG_WRITE_ONE_LOW: r_cfg.write_one_low <= i_cfg_data[5:0];
                REG_SLOT:          r_cfg.slot          <= i_cfg_data[7:0];
                REG_READ_LOW:      r_cfg.read_low      <= i_cfg_data[5:0];
                REG_READ_SAMPLE:   r_cfg.read_sample   <= i_cfg_data[5:0];
                REG_BIT_GAP:       r_cfg.bit_gap       <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/owbm_engine.sv -----
// bus sequencer: phase state, tick counter, bit shifter, crc; one beat per step
// depends on owbm_pkg
module owbm_engine #(
    parameter int TICK_COUNTER_WIDTH = owbm_pkg::TICK_CNT_W_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  owbm_pkg::t_action   i_action,
    input  logic [7:0]          i_tx_byte,
    input  logic                i_line_level,
    input  owbm_pkg::t_cfg      i_cfg,
    output owbm_pkg::t_result   o_res
);
    import owbm_pkg::*;

    localparam int W = TICK_COUNTER_WIDTH;
    localparam logic [W-1:0] CNT_MAX = '1;
    localparam logic [BIT_IDX_W-1:0] BIT_LAST = BIT_IDX_W'(BITS_PER_BYTE - 1);

    function automatic logic [W-1:0] clip_len(input logic [9:0] v);
        logic [16:0] wide;
        wide = 17'(v);
        if (v == 10'd0) begin
            return W'(1);
        end else if (wide > 17'(CNT_MAX)) begin
            return CNT_MAX;
        end else begin
            return W'(v);
        end
    endfunction

    t_phase               r_phase, n_phase;
    t_action              r_op, n_op;
    logic [W-1:0]         r_cnt, n_cnt;
    logic [BIT_IDX_W-1:0] r_bit, n_bit;
    logic [7:0]           r_shift, n_shift;
    logic [7:0]           r_rx, n_rx;
    logic [7:0]           r_crc, n_crc;
    logic                 r_absent, n_absent;

    logic [W-1:0] cnt_inc;
    logic [W-1:0] len_rst_low, len_pres, len_recov, len_slot, len_rd_low, len_gap;
    logic [W-1:0] len_rd_sum, len_rd_at;
    logic [6:0]   rd_sum;
    logic [7:0]   shift_upd;
    logic         done, rej, slot_end, step_bit, fin, drive;

    assign cnt_inc     = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + W'(1);
    assign len_rst_low = clip_len(i_cfg.reset_low);
    assign len_pres    = clip_len(i_cfg.presence_wait);
    assign len_recov   = clip_len(i_cfg.reset_recov);
    assign len_slot    = clip_len(10'(i_cfg.slot));
    assign len_rd_low  = clip_len(10'(i_cfg.read_low));
    assign len_gap     = clip_len(10'(i_cfg.bit_gap));
    assign rd_sum      = 7'(i_cfg.read_low) + 7'(i_cfg.read_sample);
    assign len_rd_sum  = clip_len(10'(rd_sum));
    assign len_rd_at   = (len_rd_sum > len_slot) ? len_slot : len_rd_sum;
    assign shift_upd   = (r_phase == PH_RD_SLOT && cnt_inc == len_rd_at)
                         ? {i_line_level, r_shift[7:1]} : r_shift;

    always_comb begin
        n_phase  = r_phase;
        n_op     = r_op;
        n_cnt    = r_cnt;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_rx     = r_rx;
        n_crc    = r_crc;
        n_absent = r_absent;
        done     = 1'b0;
        rej      = 1'b0;
        slot_end = 1'b0;
        step_bit = 1'b0;
        fin      = 1'b0;
        if (i_adv) begin
            if (i_action != ACT_TICK) begin
                if (r_phase != PH_IDLE) begin
                    rej = 1'b1;
                end else begin
                    n_op  = i_action;
                    n_cnt = '0;
                    n_bit = '0;
                    unique case (i_action)
                        ACT_RESET: begin
                            n_crc   = '0;
                            n_phase = PH_RST_LOW;
                        end
                        ACT_WRITE: begin
                            n_shift = i_tx_byte;
                            n_phase = PH_WR_SLOT;
                        end
                        default: begin
                            n_shift = '0;
                            n_phase = PH_RD_SLOT;
                        end
                    endcase
                end
            end else if (r_phase != PH_IDLE) begin
                n_cnt = cnt_inc;
                unique case (r_phase)
                    PH_RST_LOW: begin
                        if (cnt_inc >= len_rst_low) begin
                            n_phase = PH_RST_WAIT;
                            n_cnt   = '0;
                        end
                    end
                    PH_RST_WAIT: begin
                        if (cnt_inc >= len_pres) begin
                            if (i_line_level) begin
                                n_absent = 1'b1;
                                fin      = 1'b1;
                            end else begin
                                n_absent = 1'b0;
                                if (i_cfg.reset_recov == 10'd0) begin
                                    fin = 1'b1;
                                end else begin
                                    n_phase = PH_RST_RECOV;
                                    n_cnt   = '0;
                                end
                            end
                        end
                    end
                    PH_RST_RECOV: begin
                        fin = (cnt_inc >= len_recov);
                    end
                    PH_WR_SLOT: begin
                        slot_end = (cnt_inc >= len_slot);
                    end
                    PH_RD_SLOT: begin
                        n_shift  = shift_upd;
                        slot_end = (cnt_inc >= len_slot);
                    end
                    PH_GAP: begin
                        step_bit = (cnt_inc >= len_gap);
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
                if (slot_end) begin
                    if (i_cfg.bit_gap == 6'd0) begin
                        step_bit = 1'b1;
                    end else begin
                        n_phase = PH_GAP;
                        n_cnt   = '0;
                    end
                end
                if (step_bit) begin
                    if (r_bit == BIT_LAST) begin
                        if (r_op == ACT_READ) begin
                            n_rx  = shift_upd;
                            n_crc = crc8_byte(r_crc, shift_upd);
                        end
                        fin = 1'b1;
                    end else begin
                        n_bit   = r_bit + BIT_IDX_W'(1);
                        n_cnt   = '0;
                        n_phase = (r_op == ACT_WRITE) ? PH_WR_SLOT : PH_RD_SLOT;
                    end
                end
                if (fin) begin
                    n_phase = PH_IDLE;
                    n_cnt   = '0;
                    done    = 1'b1;
                end
            end
        end
    end

    // line drive for the coming tick, from the updated state
    always_comb begin
        unique case (n_phase)
            PH_RST_LOW: drive = 1'b1;
            PH_WR_SLOT: drive = !n_shift[n_bit] || (n_cnt < W'(i_cfg.write_one_low));
            PH_RD_SLOT: drive = (n_cnt < len_rd_low);
            default:    drive = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_op     <= ACT_TICK;
            r_cnt    <= '0;
            r_bit    <= '0;
            r_shift  <= '0;
            r_rx     <= '0;
            r_crc    <= '0;
            r_absent <= 1'b0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_op     <= n_op;
            r_cnt    <= n_cnt;
            r_bit    <= n_bit;
            r_shift  <= n_shift;
            r_rx     <= n_rx;
            r_crc    <= n_crc;
            r_absent <= n_absent;
        end
    end

    assign o_res.drive_low = drive;
    assign o_res.busy_res  = (n_phase != PH_IDLE);
    assign o_res.done_res  = done;
    assign o_res.no_device = n_absent;
    assign o_res.rx_byte   = n_rx;
    assign o_res.crc_value = n_crc;
    assign o_res.rejected  = rej;

endmodule

// ----- hw/rtl/one_wire_bus_master.sv -----
// 1-wire bus master top: input beat register, sequencer step, result register
// an input beat passes the input register, then the result register; one beat per cycle
// sustained while m_axis_tready holds, with the single sequencer update between the two registers
// reset: synchronous active-low i_rst_n returns to idle, clears counters, crc and flags
// and restores default timing registers; depends on owbm_pkg, owbm_cfg_regs, owbm_engine
module one_wire_bus_master #(
    parameter int TICK_COUNTER_WIDTH = owbm_pkg::TICK_CNT_W_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] tx_byte, [8] line_level, [15:9] zero
    input  logic [owbm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [owbm_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [3] no_device,
    // [11:4] rx_byte, [19:12] crc_value, [20] rejected, [23:21] zero
    output logic [owbm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import owbm_pkg::*;

    t_cfg    cfg;
    t_result res;

    logic       r_in_valid;
    t_action    r_in_action;
    logic [7:0] r_in_tx;
    logic       r_in_level;
    logic       r_out_valid;
    t_result    r_out_res;
    logic       out_free, adv;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign adv           = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_action <= t_action'(s_axis_tuser);
            r_in_tx     <= s_axis_tdata[7:0];
            r_in_level  <= s_axis_tdata[8];
        end
    end

    owbm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    owbm_engine #(
        .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_action     (r_in_action),
        .i_tx_byte    (r_in_tx),
        .i_line_level (r_in_level),
        .i_cfg        (cfg),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000,
                            r_out_res.rejected,
                            r_out_res.crc_value,
                            r_out_res.rx_byte,
                            r_out_res.no_device,
                            r_out_res.done_res,
                            r_out_res.busy_res,
                            r_out_res.drive_low};

endmodule

// ----- hw/rtl/owbm_checker.sv -----
// port-level checks for the 1-wire bus master, bound to the top level
// depends on owbm_pkg and assert_macros.svh
`include "assert_macros.svh"

module owbm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [owbm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import owbm_pkg::*;

    // stalled result beat holds
    `A_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // completion leaves the master idle
    `A_IMPLIES(a_done_idle, m_axis_tvalid && m_axis_tdata[2], !m_axis_tdata[1])

    // line is only pulled low while an operation runs
    `A_IMPLIES(a_drive_busy, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1])

    // a rejected command means an operation was running and nothing completed
    `A_IMPLIES(a_rej_busy, m_axis_tvalid && m_axis_tdata[20],
               m_axis_tdata[1] && !m_axis_tdata[2])

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- test/one_wire_bus_master_tb.sv -----
// self-checking testbench for the 1-wire bus master: command and tick beats in, status beats out
// a bit-level predictor of the sequencer and crc runs beside the block; depends on owbm_pkg
module one_wire_bus_master_tb;

    import owbm_pkg::*;

    localparam int unsigned CNT_MAX     = (1 << TICK_CNT_W_DEF) - 1;
    localparam int unsigned STALL_LIMIT = 2000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [7:0] tx_byte, [8] line_level, [15:9] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // [1:0] action
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [0] drive_low, [1] busy_res, [2] done_res, [3] no_device,
    // [11:4] rx_byte, [19:12] crc_value, [20] rejected, [23:21] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    one_wire_bus_master u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // predicted bus master state
    t_cfg        timing;
    t_phase      bus_phase;
    t_action     bus_op;
    int unsigned bus_cnt;
    logic [2:0]  bus_bit;
    logic [7:0]  bus_shift;
    logic [7:0]  bus_rx;
    logic [7:0]  bus_crc;
    logic        bus_absent;
    logic        bus_done;

    t_result     status_due[$];
    int unsigned n_errors;
    int unsigned n_items;
    int unsigned ops_done;
    int unsigned quiet_cycles;
    bit          tx_calm;
    bit          rx_calm;
    int unsigned rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned span(input int unsigned v);
        if (v == 0) return 1;
        if (v > CNT_MAX) return CNT_MAX;
        return v;
    endfunction

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ data[i];
            c  = {fb, c[7], c[6], c[5], c[4] ^ fb, c[3] ^ fb, c[2], c[1]};
        end
        return c;
    endfunction

    function automatic void model_reset();
        timing     = CFG_RESET;
        bus_phase  = PH_IDLE;
        bus_op     = ACT_TICK;
        bus_cnt    = 0;
        bus_bit    = '0;
        bus_shift  = '0;
        bus_rx     = '0;
        bus_crc    = '0;
        bus_absent = 1'b0;
        bus_done   = 1'b0;
    endfunction

    function automatic void op_complete();
        bus_phase = PH_IDLE;
        bus_cnt   = 0;
        bus_done  = 1'b1;
    endfunction

    function automatic void advance_bit();
        if (bus_bit == 3'(BITS_PER_BYTE - 1)) begin
            if (bus_op == ACT_READ) begin
                bus_rx  = bus_shift;
                bus_crc = crc8_next(bus_crc, bus_shift);
            end
            op_complete();
        end else begin
            bus_bit   = bus_bit + 3'd1;
            bus_cnt   = 0;
            bus_phase = (bus_op == ACT_WRITE) ? PH_WR_SLOT : PH_RD_SLOT;
        end
    endfunction

    function automatic void close_slot();
        if (timing.bit_gap == 0) begin
            advance_bit();
        end else begin
            bus_phase = PH_GAP;
            bus_cnt   = 0;
        end
    endfunction

    function automatic void advance_tick(input logic lvl);
        int unsigned slot_len;
        int unsigned at;
        slot_len = span(32'(timing.slot));
        if (bus_phase == PH_IDLE) return;
        if (bus_cnt < CNT_MAX) bus_cnt++;
        case (bus_phase)
            PH_RST_LOW: begin
                if (bus_cnt >= span(32'(timing.reset_low))) begin
                    bus_phase = PH_RST_WAIT;
                    bus_cnt   = 0;
                end
            end
            PH_RST_WAIT: begin
                if (bus_cnt >= span(32'(timing.presence_wait))) begin
                    if (lvl) begin
                        bus_absent = 1'b1;
                        op_complete();
                    end else begin
                        bus_absent = 1'b0;
                        if (timing.reset_recov == 0) begin
                            op_complete();
                        end else begin
                            bus_phase = PH_RST_RECOV;
                            bus_cnt   = 0;
                        end
                    end
                end
            end
            PH_RST_RECOV: begin
                if (bus_cnt >= span(32'(timing.reset_recov))) op_complete();
            end
            PH_WR_SLOT: begin
                if (bus_cnt >= slot_len) close_slot();
            end
            PH_RD_SLOT: begin
                at = span(32'(timing.read_low) + 32'(timing.read_sample));
                if (at > slot_len) at = slot_len;
                if (bus_cnt == at) bus_shift = {lvl, bus_shift[7:1]};
                if (bus_cnt >= slot_len) close_slot();
            end
            PH_GAP: begin
                if (bus_cnt >= span(32'(timing.bit_gap))) advance_bit();
            end
            default: op_complete();
        endcase
    endfunction

    function automatic logic drive_level();
        case (bus_phase)
            PH_RST_LOW: return 1'b1;
            PH_WR_SLOT: begin
                if (!bus_shift[bus_bit]) return 1'b1;
                return bus_cnt < 32'(timing.write_one_low);
            end
            PH_RD_SLOT: return bus_cnt < span(32'(timing.read_low));
            default:    return 1'b0;
        endcase
    endfunction

    function automatic t_result predict_status(input t_action act, input logic [7:0] tx,
                                               input logic lvl);
        t_result r;
        logic    turned_away;
        bus_done    = 1'b0;
        turned_away = 1'b0;
        if (act != ACT_TICK) begin
            if (bus_phase != PH_IDLE) begin
                turned_away = 1'b1;
            end else begin
                bus_op  = act;
                bus_cnt = 0;
                bus_bit = '0;
                case (act)
                    ACT_RESET: begin
                        bus_crc   = '0;
                        bus_phase = PH_RST_LOW;
                    end
                    ACT_WRITE: begin
                        bus_shift = tx;
                        bus_phase = PH_WR_SLOT;
                    end
                    default: begin
                        bus_shift = '0;
                        bus_phase = PH_RD_SLOT;
                    end
                endcase
            end
        end else begin
            advance_tick(lvl);
        end
        r.drive_low = drive_level();
        r.busy_res  = (bus_phase != PH_IDLE);
        r.done_res  = bus_done;
        r.no_device = bus_absent;
        r.rx_byte   = bus_rx;
        r.crc_value = bus_crc;
        r.rejected  = turned_away;
        return r;
    endfunction

    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_beat(input t_action act, input logic [7:0] tx, input logic lvl);
        int unsigned gap;
        gap = pick_gap(tx_calm);
        if ($urandom_range(0, 299) == 0) tx_calm = !tx_calm;
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {7'd0, lvl, tx};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        status_due.push_back(predict_status(act, tx, lvl));
        n_items++;
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic apply_timing(input t_cfg c);
        wait_quiet();
        write_reg(REG_RESET_LOW,     c.reset_low);
        write_reg(REG_PRESENCE_WAIT, c.presence_wait);
        write_reg(REG_RESET_RECOV,   c.reset_recov);
        write_reg(REG_WRITE_ONE_LOW, 10'(c.write_one_low));
        write_reg(REG_SLOT,          10'(c.slot));
        write_reg(REG_READ_LOW,      10'(c.read_low));
        write_reg(REG_READ_SAMPLE,   10'(c.read_sample));
        write_reg(REG_BIT_GAP,       10'(c.bit_gap));
        timing = c;
    endtask

    // ticks until the running operation ends; pat gives the line level per bit, rough adds stray commands and levels
    task automatic finish_op(input logic [7:0] pat, input bit rough);
        int unsigned r;
        logic        lvl;
        while (bus_phase != PH_IDLE) begin
            r = $urandom_range(0, 99);
            if (rough && r < 2) begin
                send_beat(t_action'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
            end else begin
                lvl = pat[bus_bit];
                if (rough && r >= 94) lvl = 1'($urandom);
                send_beat(ACT_TICK, 8'($urandom), lvl);
            end
        end
        ops_done++;
    endtask

    task automatic run_op(input t_action act, input logic [7:0] tx, input logic [7:0] pat,
                          input bit rough);
        send_beat(act, tx, 1'($urandom));
        finish_op(pat, rough);
    endtask

    function automatic t_cfg rand_timing();
        t_cfg c;
        bit   wide;
        wide            = ($urandom_range(0, 3) == 0);
        c.reset_low     = 10'($urandom_range(0, 8));
        c.presence_wait = 10'($urandom_range(0, 8));
        c.reset_recov   = 10'($urandom_range(0, 8));
        c.write_one_low = wide ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 10));
        c.slot          = 8'($urandom_range(0, 8));
        c.read_low      = wide ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 6));
        c.read_sample   = wide ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 6));
        c.bit_gap       = 6'($urandom_range(0, 2));
        return c;
    endfunction

    task automatic test_defaults();
        send_beat(ACT_TICK, 8'hFF, 1'b1);
        send_beat(ACT_TICK, 8'h00, 1'b0);
        // a read at reset-time timing; commands arriving mid-operation are turned away
        send_beat(ACT_READ,  8'h00, 1'b1);
        send_beat(ACT_WRITE, 8'h3C, 1'b0);
        send_beat(ACT_RESET, 8'h00, 1'b0);
        send_beat(ACT_READ,  8'hFF, 1'b1);
        finish_op(8'h5A, 1'b0);
    endtask

    task automatic test_zero_lengths();
        apply_timing('0);
        run_op(ACT_RESET, 8'h00, 8'h00, 1'b0);
        run_op(ACT_WRITE, 8'hA5, 8'h00, 1'b0);
        run_op(ACT_READ,  8'h00, 8'h3C, 1'b0);
        run_op(ACT_RESET, 8'h00, 8'hFF, 1'b0);
    endtask

    task automatic test_long_lengths();
        t_cfg c;
        // six-bit settings at their top, far past a short slot
        c = '{reset_low: 10'd2, presence_wait: 10'd3, reset_recov: 10'd1,
              write_one_low: 6'd63, slot: 8'd3, read_low: 6'd63, read_sample: 6'd63,
              bit_gap: 6'd2};
        apply_timing(c);
        run_op(ACT_RESET, 8'h00, 8'h00, 1'b0);
        run_op(ACT_WRITE, 8'h96, 8'h00, 1'b0);
        run_op(ACT_READ,  8'h00, 8'h69, 1'b0);
    endtask

    task automatic test_slot_overlaps();
        t_cfg c;
        // one-tick read low time and read sample landing on the slot's last tick
        c = '{reset_low: 10'd1, presence_wait: 10'd1, reset_recov: 10'd1,
              write_one_low: 6'd5, slot: 8'd5, read_low: 6'd1, read_sample: 6'd4,
              bit_gap: 6'd1};
        apply_timing(c);
        run_op(ACT_WRITE, 8'h5A, 8'h00, 1'b0);
        run_op(ACT_RESET, 8'h00, 8'h00, 1'b0);
        run_op(ACT_READ,  8'h00, 8'hC3, 1'b0);
    endtask

    task automatic test_random_traffic();
        int unsigned r;
        int unsigned first;
        t_action     act;
        first = ops_done;
        while (n_items < 700 || ops_done < first + 4) begin
            apply_timing(rand_timing());
            repeat (2) begin
                repeat ($urandom_range(0, 2)) send_beat(ACT_TICK, 8'($urandom), 1'($urandom));
                r   = $urandom_range(0, 99);
                act = (r < 25) ? ACT_RESET : (r < 60) ? ACT_WRITE : ACT_READ;
                run_op(act, 8'($urandom), 8'($urandom), 1'b1);
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin : status_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (status_due.size() == 0) begin
                $error("status beat with nothing outstanding: 0x%0h", m_axis_tdata);
                n_errors++;
            end else begin
                want = status_due.pop_front();
                compare_field("drive_low", 8'(want.drive_low), 8'(m_axis_tdata[0]));
                compare_field("busy_res",  8'(want.busy_res),  8'(m_axis_tdata[1]));
                compare_field("done_res",  8'(want.done_res),  8'(m_axis_tdata[2]));
                compare_field("no_device", 8'(want.no_device), 8'(m_axis_tdata[3]));
                compare_field("rx_byte",   want.rx_byte,       m_axis_tdata[11:4]);
                compare_field("crc_value", want.crc_value,     m_axis_tdata[19:12]);
                compare_field("rejected",  8'(want.rejected),  8'(m_axis_tdata[20]));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        rx_calm       = 1'b0;
        rx_hold       = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_axis_tready <= 1'b1;
                rx_hold = pick_gap(rx_calm);
            end
            if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_TICK;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        n_errors      = 0;
        n_items       = 0;
        ops_done      = 0;
        quiet_cycles  = 0;
        tx_calm       = 1'b0;
        model_reset();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults();
        test_zero_lengths();
        test_long_lengths();
        test_slot_overlaps();
        test_random_traffic();

        wait_quiet();
        repeat (8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
